>>> rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg - shared types, constants and step tables
// Power state and sequence codes, step table rows and the control structs
// passed between the sequencer, the step unit and the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  // Table sizing
  localparam int STEP_TABLE_DEPTH = 16;
  localparam int IDX_W            = $clog2(STEP_TABLE_DEPTH + 1);
  localparam int MAX_RES          = 4;
  localparam int SLOT_W           = $clog2(MAX_RES);
  localparam int CNT_W            = $clog2(MAX_RES + 1);

  // Field widths
  localparam int STEP_W  = 4;
  localparam int DLY_W   = 8;
  localparam int CFG_W   = 8;
  localparam int CIDX_W  = 2;
  localparam int IN_W    = 8;
  localparam int OUT_W   = 16;
  localparam int PINS_W  = 6;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_S0_EXIT_DEBOUNCE   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MAIN_POWER_TIMEOUT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_S3_WAKE_DELAY      = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] S0_EXIT_DEBOUNCE_RST   = 8'd10;
  localparam logic [CFG_W-1:0] MAIN_POWER_TIMEOUT_RST = 8'd50;
  localparam logic [CFG_W-1:0] S3_WAKE_DELAY_RST      = 8'd20;

  // Start points of the sequences
  localparam logic [IDX_W-1:0] SEQ_FIRST_IDX  = IDX_W'(1);
  localparam logic [IDX_W-1:0] S3_RESUME_IDX  = IDX_W'(3);

  typedef enum logic [2:0] {
    PS_S0   = 3'd0,
    PS_S3   = 3'd1,
    PS_S5   = 3'd2,
    PS_S5S0 = 3'd3,
    PS_S3S0 = 3'd4,
    PS_S0S3 = 3'd5,
    PS_S0S5 = 3'd6
  } pwr_state_t;

  typedef enum logic [1:0] {
    SEQ_S5S0 = 2'd0,
    SEQ_S0S5 = 2'd1,
    SEQ_S3S0 = 2'd2,
    SEQ_S0S3 = 2'd3
  } seq_id_t;

  typedef enum logic [2:0] {
    PIN_NONE = 3'd0,
    PIN_S3   = 3'd1,
    PIN_S5   = 3'd2,
    PIN_AON  = 3'd3,
    PIN_CORE = 3'd4,
    PIN_VR   = 3'd5
  } pin_sel_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EVAL,
    CS_WALK,
    CS_CLOSE
  } ctl_state_t;

  // Input pins, slp_s3 in the lowest bit
  typedef struct packed {
    logic main_power;
    logic vr_ok;
    logic core_rail_good;
    logic always_on_good;
    logic slp_s5;
    logic slp_s3;
  } pins_t;

  typedef struct packed {
    logic [DLY_W-1:0] delay;
    pin_sel_t         pin;
    logic             level;
  } seq_row_t;

  // Step unit verdict for the current row
  typedef struct packed {
    logic       in_range;
    logic       take;
    logic       stop;
    logic       at_end;
    seq_row_t   row;
    pwr_state_t target;
  } step_res_t;

  // Record of one reported step
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [STEP_W-1:0] step;
  } rec_t;

  // Request to send the results of one tick
  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] count;
    seq_id_t          seq;
    pwr_state_t       pstate;
  } emit_req_t;

  function automatic seq_row_t mk_row(input int d, input pin_sel_t p, input logic l);
    seq_row_t r;
    r.delay = DLY_W'(d);
    r.pin   = p;
    r.level = l;
    return r;
  endfunction

  // Constant step tables
  function automatic seq_row_t seq_row(input seq_id_t sq, input logic [IDX_W-1:0] idx);
    seq_row_t r;
    r = mk_row(0, PIN_NONE, 1'b0);
    unique case (sq)
      SEQ_S5S0: begin
        case (int'(idx))
          1:  r = mk_row(32,  PIN_NONE, 1'b0);
          2:  r = mk_row(20,  PIN_AON,  1'b1);
          3:  r = mk_row(30,  PIN_NONE, 1'b0);
          4:  r = mk_row(20,  PIN_NONE, 1'b0);
          5:  r = mk_row(4,   PIN_S5,   1'b1);
          6:  r = mk_row(10,  PIN_S3,   1'b1);
          8:  r = mk_row(10,  PIN_NONE, 1'b0);
          9:  r = mk_row(1,   PIN_NONE, 1'b0);
          10: r = mk_row(20,  PIN_CORE, 1'b1);
          12: r = mk_row(10,  PIN_NONE, 1'b0);
          13: r = mk_row(10,  PIN_VR,   1'b1);
          14: r = mk_row(126, PIN_NONE, 1'b0);
          default: r = mk_row(0, PIN_NONE, 1'b0);
        endcase
      end
      SEQ_S0S5: begin
        case (int'(idx))
          1:  r = mk_row(1,   PIN_NONE, 1'b0);
          3:  r = mk_row(0,   PIN_CORE, 1'b0);
          4:  r = mk_row(30,  PIN_NONE, 1'b0);
          5:  r = mk_row(20,  PIN_NONE, 1'b0);
          6:  r = mk_row(1,   PIN_VR,   1'b0);
          7:  r = mk_row(250, PIN_NONE, 1'b0);
          default: r = mk_row(0, PIN_NONE, 1'b0);
        endcase
      end
      SEQ_S3S0: begin
        case (int'(idx))
          1:  r = mk_row(20,  PIN_NONE, 1'b0);
          4:  r = mk_row(1,   PIN_S3,   1'b1);
          5:  r = mk_row(10,  PIN_NONE, 1'b0);
          6:  r = mk_row(10,  PIN_CORE, 1'b1);
          8:  r = mk_row(10,  PIN_NONE, 1'b0);
          9:  r = mk_row(1,   PIN_VR,   1'b1);
          10: r = mk_row(126, PIN_NONE, 1'b0);
          default: r = mk_row(0, PIN_NONE, 1'b0);
        endcase
      end
      SEQ_S0S3: begin
        case (int'(idx))
          1:  r = mk_row(1,   PIN_S3,   1'b0);
          3:  r = mk_row(0,   PIN_CORE, 1'b0);
          4:  r = mk_row(30,  PIN_NONE, 1'b0);
          5:  r = mk_row(1,   PIN_VR,   1'b0);
          default: r = mk_row(0, PIN_NONE, 1'b0);
        endcase
      end
      default: r = mk_row(0, PIN_NONE, 1'b0);
    endcase
    return r;
  endfunction

  // Table length, clipped to the table depth
  function automatic logic [IDX_W-1:0] seq_len(input seq_id_t sq);
    int n;
    n = 0;
    unique case (sq)
      SEQ_S5S0: n = 16;
      SEQ_S0S5: n = 10;
      SEQ_S3S0: n = 12;
      SEQ_S0S3: n = 7;
      default:  n = 0;
    endcase
    if (n > STEP_TABLE_DEPTH) n = STEP_TABLE_DEPTH;
    return IDX_W'(n);
  endfunction

  function automatic pwr_state_t seq_target(input seq_id_t sq);
    pwr_state_t t;
    unique case (sq)
      SEQ_S5S0: t = PS_S0;
      SEQ_S0S5: t = PS_S5;
      SEQ_S3S0: t = PS_S0;
      SEQ_S0S3: t = PS_S3;
      default:  t = PS_S5;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pps_step_unit.sv
// ----------------------------------------------------------------------------
// pps_step_unit - shared step evaluator
// Looks up one table row and decides whether the step is taken and whether
// the walk stops after it; also flags the end of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_step_unit (
  input  wire pps_pkg::seq_id_t               seq,
  input  wire logic [pps_pkg::IDX_W-1:0]      idx,
  input  wire logic [pps_pkg::CNT_W-1:0]      n_done,
  input  wire pps_pkg::pins_t                 pins,
  output pps_pkg::step_res_t                  res
);

  pps_pkg::seq_row_t       row;
  logic [pps_pkg::IDX_W-1:0] len;
  logic                    pin_lvl;

  assign row = pps_pkg::seq_row(seq, idx);
  assign len = pps_pkg::seq_len(seq);

  // Pin selected by the row
  always_comb begin
    case (row.pin)
      pps_pkg::PIN_S3:   pin_lvl = pins.slp_s3;
      pps_pkg::PIN_S5:   pin_lvl = pins.slp_s5;
      pps_pkg::PIN_AON:  pin_lvl = pins.always_on_good;
      pps_pkg::PIN_CORE: pin_lvl = pins.core_rail_good;
      pps_pkg::PIN_VR:   pin_lvl = pins.vr_ok;
      default:           pin_lvl = 1'b0;
    endcase
  end

  // Action steps always go; a check goes on a level match and always stops
  always_comb begin
    res.row      = row;
    res.target   = pps_pkg::seq_target(seq);
    res.at_end   = (idx >= len);
    res.in_range = (idx < len) && (n_done < pps_pkg::CNT_W'(pps_pkg::MAX_RES));
    if (row.pin == pps_pkg::PIN_NONE) begin
      res.take = 1'b1;
      res.stop = (row.delay != '0);
    end else begin
      res.take = (pin_lvl == row.level);
      res.stop = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pps_result_buf.sv
// ----------------------------------------------------------------------------
// pps_result_buf - per-tick result buffer and output register
// Collects the step indexes reported during a tick, then sends them out
// with the final power state once the tick is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_result_buf (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pps_pkg::rec_t                rec,
  input  wire pps_pkg::emit_req_t           emit,
  output logic                              busy,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [pps_pkg::OUT_W-1:0]         out_tdata,
  output logic                              out_tlast
);

  logic [pps_pkg::STEP_W-1:0] rep_r [pps_pkg::MAX_RES];
  logic                        busy_r, busy_nxt;
  logic                        vld_r, vld_nxt;
  logic [pps_pkg::SLOT_W-1:0]  sel_r, sel_nxt;
  logic [pps_pkg::CNT_W-1:0]   cnt_r;
  pps_pkg::seq_id_t            seq_r;
  pps_pkg::pwr_state_t         pst_r;
  logic [pps_pkg::OUT_W-1:0]   data_r;
  logic                        last_r;
  logic                        load;
  logic                        last_one;

  // Load the output register while results are pending and it is free or being drained
  assign load     = busy_r && (!vld_r || out_tready);
  assign last_one = (cnt_r == '0) ||
                    (cnt_r == pps_pkg::CNT_W'(sel_r) + pps_pkg::CNT_W'(1));

  always_comb begin
    busy_nxt = busy_r;
    sel_nxt  = sel_r;
    vld_nxt  = vld_r;
    if (out_tready) vld_nxt = 1'b0;
    if (load) begin
      vld_nxt = 1'b1;
      sel_nxt = sel_r + 1'b1;
      if (last_one) busy_nxt = 1'b0;
    end
    if (emit.go) begin
      busy_nxt = 1'b1;
      sel_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
      sel_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
      sel_r  <= sel_nxt;
    end
  end

  // Step store and payload
  always_ff @(posedge clk) begin
    if (rec.we) rep_r[rec.slot] <= rec.step;
    if (emit.go) begin
      cnt_r <= emit.count;
      seq_r <= emit.seq;
      pst_r <= emit.pstate;
    end
    if (load) begin
      last_r <= last_one;
      if (cnt_r == '0) begin
        // idle tick: one empty result
        data_r <= {6'b0, pst_r, {pps_pkg::STEP_W{1'b0}}, 2'b00, 1'b0};
      end else begin
        data_r <= {6'b0, pst_r, rep_r[sel_r], seq_r, 1'b1};
      end
    end
  end

  assign busy       = busy_r;
  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

>>> rtl/platform_power_state_sequencer.sv
// ----------------------------------------------------------------------------
// platform_power_state_sequencer - system power state sequencer
// Advances the power state once per 1 ms tick and walks the power-up and
// power-down step tables, reporting each step taken or check passed.
// ----------------------------------------------------------------------------
//  Channel  Direction  Width  Contents
//  in_*     slave      8      pins: slp_s3, slp_s5, always_on_good,
//                             core_rail_good, vr_ok, main_power
//  out_*    master     16+1   step_done, sequence_res, step, power_state; tlast
//  cfg_*    write      2+8    s0_exit_debounce, main_power_timeout,
//                             s3_wake_delay
//
//  A tick runs through accept, evaluate, then, when a table is walked, one
//  step-unit evaluation per step (the last one idle when the walk runs out
//  without a stop) and close; each result is then loaded into the output
//  register in turn (at most 4; the next tick waits for the last load).
//  Reset is synchronous, active low; output stalls hold off the next tick without limit.
// ----------------------------------------------------------------------------
`default_nettype none

module platform_power_state_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [0] slp_s3 [1] slp_s5 [2] always_on_good [3] core_rail_good [4] vr_ok
  // [5] main_power [7:6] zero
  input  wire logic [pps_pkg::IN_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] step_done [2:1] sequence_res [6:3] step [9:7] power_state [15:10] zero
  output logic [pps_pkg::OUT_W-1:0]          out_tdata,
  output logic                               out_tlast,
  input  wire logic                          cfg_we,
  input  wire logic [pps_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [pps_pkg::CFG_W-1:0]     cfg_wdata
);

  pps_pkg::ctl_state_t          state_r, state_nxt;
  pps_pkg::pwr_state_t          pst_r, pst_nxt;
  logic [pps_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [pps_pkg::DLY_W-1:0]    dly_r, dly_nxt;
  logic [pps_pkg::DLY_W-1:0]    dbc_r, dbc_nxt;
  logic [pps_pkg::DLY_W-1:0]    mpw_r, mpw_nxt;
  logic [pps_pkg::CNT_W-1:0]    n_r, n_nxt;
  pps_pkg::seq_id_t             seq_r, seq_nxt;
  pps_pkg::pins_t               pins_r, pins_nxt;
  logic [pps_pkg::CFG_W-1:0]    exit_dbc_r, mp_tmo_r, wake_dly_r;

  pps_pkg::step_res_t           su;
  pps_pkg::rec_t                rec;
  pps_pkg::emit_req_t           emit;
  logic                         emit_busy;
  logic                         in_xfer;
  logic                         walk_en;
  pps_pkg::seq_id_t             walk_seq;
  logic [pps_pkg::DLY_W-1:0]    dly_dec;
  logic                         dly_hold;
  logic [pps_pkg::DLY_W-1:0]    mpw_inc;

  assign in_tready = (state_r == pps_pkg::CS_IDLE) && !emit_busy;
  assign in_xfer   = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_dbc_r <= pps_pkg::S0_EXIT_DEBOUNCE_RST;
      mp_tmo_r   <= pps_pkg::MAIN_POWER_TIMEOUT_RST;
      wake_dly_r <= pps_pkg::S3_WAKE_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pps_pkg::CFG_S0_EXIT_DEBOUNCE:   exit_dbc_r <= cfg_wdata;
        pps_pkg::CFG_MAIN_POWER_TIMEOUT: mp_tmo_r   <= cfg_wdata;
        pps_pkg::CFG_S3_WAKE_DELAY:      wake_dly_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Which table the current state walks, and pending delay
  always_comb begin
    walk_en  = 1'b0;
    walk_seq = pps_pkg::SEQ_S5S0;
    case (pst_r)
      pps_pkg::PS_S5S0: begin
        walk_en  = pins_r.main_power;
        walk_seq = pps_pkg::SEQ_S5S0;
      end
      pps_pkg::PS_S3S0: begin
        walk_en  = 1'b1;
        walk_seq = pps_pkg::SEQ_S3S0;
      end
      pps_pkg::PS_S0S3: begin
        walk_en  = 1'b1;
        walk_seq = pps_pkg::SEQ_S0S3;
      end
      pps_pkg::PS_S0S5: begin
        walk_en  = 1'b1;
        walk_seq = pps_pkg::SEQ_S0S5;
      end
      default: ;
    endcase
  end

  assign dly_dec  = dly_r - 1'b1;
  assign dly_hold = (dly_r != '0) && (dly_dec != '0);
  assign mpw_inc  = (mpw_r == '1) ? mpw_r : mpw_r + 1'b1;

  pps_step_unit u_step (
    .seq    (seq_r),
    .idx    (idx_r),
    .n_done (n_r),
    .pins   (pins_r),
    .res    (su)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pps_pkg::CS_IDLE:  if (in_xfer) state_nxt = pps_pkg::CS_EVAL;
      pps_pkg::CS_EVAL:  state_nxt = (walk_en && !dly_hold) ? pps_pkg::CS_WALK
                                                            : pps_pkg::CS_IDLE;
      pps_pkg::CS_WALK:  if (!su.in_range || su.stop) state_nxt = pps_pkg::CS_CLOSE;
      pps_pkg::CS_CLOSE: state_nxt = pps_pkg::CS_IDLE;
      default:           state_nxt = pps_pkg::CS_IDLE;
    endcase
  end

  // Datapath updates and buffer requests
  always_comb begin
    pst_nxt  = pst_r;
    idx_nxt  = idx_r;
    dly_nxt  = dly_r;
    dbc_nxt  = dbc_r;
    mpw_nxt  = mpw_r;
    n_nxt    = n_r;
    seq_nxt  = seq_r;
    pins_nxt = pins_r;
    rec      = '0;
    emit     = '0;
    unique case (state_r)
      pps_pkg::CS_IDLE: begin
        if (in_xfer) begin
          pins_nxt = pps_pkg::pins_t'(in_tdata[pps_pkg::PINS_W-1:0]);
          n_nxt    = '0;
        end
      end
      pps_pkg::CS_EVAL: begin
        seq_nxt = walk_seq;
        case (pst_r)
          pps_pkg::PS_S0: begin
            if (!pins_r.slp_s3) begin
              if (dbc_r > exit_dbc_r) begin
                pst_nxt = pins_r.slp_s5 ? pps_pkg::PS_S0S3 : pps_pkg::PS_S0S5;
                idx_nxt = pps_pkg::SEQ_FIRST_IDX;
                dly_nxt = '0;
              end else if (dbc_r != '1) begin
                dbc_nxt = dbc_r + 1'b1;
              end
            end else begin
              dbc_nxt = '0;
            end
          end
          pps_pkg::PS_S3: begin
            if (pins_r.slp_s3) begin
              pst_nxt = pps_pkg::PS_S3S0;
              idx_nxt = pps_pkg::S3_RESUME_IDX;
              dly_nxt = wake_dly_r;
            end
          end
          pps_pkg::PS_S5: begin
            if (pins_r.slp_s3 && pins_r.slp_s5) begin
              pst_nxt = pps_pkg::PS_S5S0;
              idx_nxt = pps_pkg::SEQ_FIRST_IDX;
              dly_nxt = '0;
            end
          end
          pps_pkg::PS_S5S0: begin
            if (pins_r.main_power) begin
              mpw_nxt = '0;
            end else begin
              mpw_nxt = mpw_inc;
              if (mpw_inc > mp_tmo_r) begin
                pst_nxt = pps_pkg::PS_S0S5;
                idx_nxt = pps_pkg::SEQ_FIRST_IDX;
                dly_nxt = '0;
              end
            end
          end
          pps_pkg::PS_S3S0, pps_pkg::PS_S0S3, pps_pkg::PS_S0S5: ;
          default: pst_nxt = pps_pkg::PS_S5;
        endcase
        if (walk_en && dly_r != '0) dly_nxt = dly_dec;
        // no table step this tick: report idle
        if (!(walk_en && !dly_hold)) begin
          emit.go     = 1'b1;
          emit.count  = '0;
          emit.seq    = walk_seq;
          emit.pstate = pst_nxt;
        end
      end
      pps_pkg::CS_WALK: begin
        if (su.in_range && su.take) begin
          rec.we   = 1'b1;
          rec.slot = n_r[pps_pkg::SLOT_W-1:0];
          rec.step = idx_r[pps_pkg::STEP_W-1:0];
          n_nxt    = n_r + 1'b1;
          idx_nxt  = idx_r + 1'b1;
          dly_nxt  = su.row.delay;
        end
      end
      pps_pkg::CS_CLOSE: begin
        // table end enters the target state
        if (su.at_end) begin
          pst_nxt = su.target;
          idx_nxt = '0;
          dly_nxt = '0;
        end
        emit.go     = 1'b1;
        emit.count  = n_r;
        emit.seq    = seq_r;
        emit.pstate = pst_nxt;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pps_pkg::CS_IDLE;
      pst_r   <= pps_pkg::PS_S5;
      idx_r   <= '0;
      dly_r   <= '0;
      dbc_r   <= '0;
      mpw_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pst_r   <= pst_nxt;
      idx_r   <= idx_nxt;
      dly_r   <= dly_nxt;
      dbc_r   <= dbc_nxt;
      mpw_r   <= mpw_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r  <= seq_nxt;
    pins_r <= pins_nxt;
  end

  pps_result_buf u_res (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec        (rec),
    .emit       (emit),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Checks
  a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= pps_pkg::CNT_W'(pps_pkg::MAX_RES))
    else $error("step result count above limit");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == pps_pkg::CS_EVAL)
    else $error("accepted tick not evaluated");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit.go |=> state_r == pps_pkg::CS_IDLE && emit_busy)
    else $error("result send not started at tick end");

  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pps_pkg::CS_IDLE |-> idx_r < pps_pkg::IDX_W'(pps_pkg::STEP_TABLE_DEPTH))
    else $error("step index left past table end");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for platform_power_state_sequencer
// Sends ticks of pin levels and checks every step report against a
// cycle-free model of the power state machine and its four step tables.
// Pins are steered through the S5 hold, the main-power gate, the whole
// S5 -> S0 power-up table and the S0 exit debounce into power down.
// ----------------------------------------------------------------------------

module tb;
  import pps_pkg::*;

  localparam int RUN_LIMIT   = 1000000;
  localparam int IDLE_SETTLE = 16;
  localparam logic [15:0] RX_MASK = 16'b1100_1011_0111_0010;

  typedef enum int {GOAL_UP, GOAL_SLEEP, GOAL_OFF} goal_t;

  // one row of a step table
  typedef struct packed {
    logic [7:0] dly;
    pin_sel_t   pin;
    logic       lvl;
  } walk_row_t;

  // one expected step report
  typedef struct packed {
    logic       done;
    logic [1:0] sq;
    logic [3:0] step;
    logic [2:0] ps;
    logic       is_last;
  } step_report_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // [0] slp_s3 [1] slp_s5 [2] always_on_good [3] core_rail_good [4] vr_ok
  // [5] main_power [7:6] zero
  logic [IN_W-1:0]     in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [0] step_done [2:1] sequence_res [6:3] step [9:7] power_state [15:10] zero
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tlast;
  logic                cfg_we     = 1'b0;
  logic [CIDX_W-1:0]   cfg_index  = CFG_S0_EXIT_DEBOUNCE;
  logic [CFG_W-1:0]    cfg_wdata  = '0;

  // model state
  pwr_state_t  ps_now;
  logic [4:0]  idx_now;
  logic [7:0]  dly_now;
  logic [7:0]  deb_cnt;
  logic [7:0]  mpw_cnt;
  logic [7:0]  debounce_lim;
  logic [7:0]  mp_timeout;
  logic [7:0]  wake_dly;
  logic [3:0]  steps_taken[$];

  step_report_t expected_reports[$];
  int mismatch_count = 0;
  int reports_seen   = 0;
  int burst_left     = 0;
  int noise_pct      = 12;
  int cycle_count    = 0;
  int rx_cyc         = 0;
  int rx_hold        = 0;

  platform_power_state_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the sequencer
  // --------------------------------------------------------------------------

  function automatic walk_row_t rw(input int d, input pin_sel_t p, input logic l);
    walk_row_t r;
    r.dly = d[7:0];
    r.pin = p;
    r.lvl = l;
    return r;
  endfunction

  // step tables; rows not listed are zero-delay actions
  function automatic walk_row_t step_row(input seq_id_t sq, input int idx);
    walk_row_t r;
    r = rw(0, PIN_NONE, 1'b0);
    case (sq)
      SEQ_S5S0: begin
        case (idx)
          1:  r = rw(32, PIN_NONE, 1'b0);
          2:  r = rw(20, PIN_AON, 1'b1);
          3:  r = rw(30, PIN_NONE, 1'b0);
          4:  r = rw(20, PIN_NONE, 1'b0);
          5:  r = rw(4, PIN_S5, 1'b1);
          6:  r = rw(10, PIN_S3, 1'b1);
          8:  r = rw(10, PIN_NONE, 1'b0);
          9:  r = rw(1, PIN_NONE, 1'b0);
          10: r = rw(20, PIN_CORE, 1'b1);
          12: r = rw(10, PIN_NONE, 1'b0);
          13: r = rw(10, PIN_VR, 1'b1);
          14: r = rw(126, PIN_NONE, 1'b0);
          default: ;
        endcase
      end
      SEQ_S0S5: begin
        case (idx)
          1: r = rw(1, PIN_NONE, 1'b0);
          3: r = rw(0, PIN_CORE, 1'b0);
          4: r = rw(30, PIN_NONE, 1'b0);
          5: r = rw(20, PIN_NONE, 1'b0);
          6: r = rw(1, PIN_VR, 1'b0);
          7: r = rw(250, PIN_NONE, 1'b0);
          default: ;
        endcase
      end
      SEQ_S3S0: begin
        case (idx)
          1:  r = rw(20, PIN_NONE, 1'b0);
          4:  r = rw(1, PIN_S3, 1'b1);
          5:  r = rw(10, PIN_NONE, 1'b0);
          6:  r = rw(10, PIN_CORE, 1'b1);
          8:  r = rw(10, PIN_NONE, 1'b0);
          9:  r = rw(1, PIN_VR, 1'b1);
          10: r = rw(126, PIN_NONE, 1'b0);
          default: ;
        endcase
      end
      default: begin
        case (idx)
          1: r = rw(1, PIN_S3, 1'b0);
          3: r = rw(0, PIN_CORE, 1'b0);
          4: r = rw(30, PIN_NONE, 1'b0);
          5: r = rw(1, PIN_VR, 1'b0);
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic int table_len(input seq_id_t sq);
    case (sq)
      SEQ_S5S0: return 16;
      SEQ_S0S5: return 10;
      SEQ_S3S0: return 12;
      default:  return 7;
    endcase
  endfunction

  function automatic pwr_state_t table_end_state(input seq_id_t sq);
    case (sq)
      SEQ_S0S5: return PS_S5;
      SEQ_S0S3: return PS_S3;
      default:  return PS_S0;
    endcase
  endfunction

  function automatic void enter_seq(input pwr_state_t s, input int idx, input logic [7:0] d);
    ps_now  = s;
    idx_now = idx[4:0];
    dly_now = d;
  endfunction

  // walks one table for one tick, collecting the steps it reports
  function automatic void walk_seq(input seq_id_t sq, input logic [5:0] p);
    walk_row_t r;
    int        len;
    bit        halt;
    len  = table_len(sq);
    halt = 1'b0;
    if (dly_now != 0) begin
      dly_now--;
      if (dly_now != 0) return;
    end
    while (!halt && idx_now < len && steps_taken.size() < MAX_RES) begin
      r = step_row(sq, idx_now);
      if (r.pin == PIN_NONE) begin
        steps_taken.push_back(idx_now[3:0]);
        dly_now = r.dly;
        idx_now++;
        if (dly_now != 0) halt = 1'b1;
      end else begin
        if (p[int'(r.pin) - 1] == r.lvl) begin
          steps_taken.push_back(idx_now[3:0]);
          dly_now = r.dly;
          idx_now++;
        end
        halt = 1'b1;
      end
    end
    if (idx_now >= len) begin
      ps_now  = table_end_state(sq);
      idx_now = '0;
      dly_now = '0;
    end
  endfunction

  // advances the model by one tick and queues the reports it causes
  function automatic void predict_tick(input logic [5:0] p);
    step_report_t rep;
    seq_id_t      sq;
    sq = SEQ_S5S0;
    steps_taken.delete();
    case (ps_now)
      PS_S0: begin
        if (!p[0]) begin
          if (deb_cnt > debounce_lim) begin
            enter_seq(PS_S0S3, 1, 8'd0);
            if (!p[1]) enter_seq(PS_S0S5, 1, 8'd0);
          end else if (deb_cnt != 8'hFF) begin
            deb_cnt++;
          end
        end else begin
          deb_cnt = '0;
        end
      end
      PS_S3: if (p[0]) enter_seq(PS_S3S0, 3, wake_dly);
      PS_S5: if (p[0] && p[1]) enter_seq(PS_S5S0, 1, 8'd0);
      PS_S5S0: begin
        if (p[5]) begin
          sq = SEQ_S5S0;
          walk_seq(sq, p);
          mpw_cnt = '0;
        end else begin
          if (mpw_cnt != 8'hFF) mpw_cnt++;
          if (mpw_cnt > mp_timeout) enter_seq(PS_S0S5, 1, 8'd0);
        end
      end
      PS_S3S0: begin
        sq = SEQ_S3S0;
        walk_seq(sq, p);
      end
      PS_S0S3: begin
        sq = SEQ_S0S3;
        walk_seq(sq, p);
      end
      PS_S0S5: begin
        sq = SEQ_S0S5;
        walk_seq(sq, p);
      end
      default: ps_now = PS_S5;
    endcase

    if (steps_taken.size() == 0) begin
      rep = '{done: 1'b0, sq: 2'd0, step: 4'd0, ps: ps_now, is_last: 1'b1};
      expected_reports.push_back(rep);
    end else begin
      foreach (steps_taken[i]) begin
        rep.done    = 1'b1;
        rep.sq      = sq;
        rep.step    = steps_taken[i];
        rep.ps      = ps_now;
        rep.is_last = (i == steps_taken.size() - 1);
        expected_reports.push_back(rep);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Pin selection
  // --------------------------------------------------------------------------

  function automatic goal_t goal_toward(input pwr_state_t target);
    if (ps_now == PS_S0) begin
      if (target == PS_S3 || target == PS_S0S3) return GOAL_SLEEP;
      if (target == PS_S5 || target == PS_S0S5) return GOAL_OFF;
      return GOAL_UP;
    end
    if (ps_now == PS_S5S0 && target == PS_S0S5) return GOAL_OFF;
    return GOAL_UP;
  endfunction

  // mostly pins that move the state toward the goal, some plain noise
  function automatic logic [5:0] pick_pins(input goal_t g);
    logic [5:0] p;
    walk_row_t  r;
    seq_id_t    sq;
    p = $urandom_range(0, 63);
    if ($urandom_range(0, 99) < noise_pct) return p;
    case (ps_now)
      PS_S5: if (g == GOAL_UP) p[1:0] = 2'b11;
      PS_S3: p[0] = (g == GOAL_UP);
      PS_S0: begin
        case (g)
          GOAL_UP:    p[0] = ($urandom_range(0, 9) != 0);
          GOAL_SLEEP: p[1:0] = 2'b10;
          default:    p[1:0] = 2'b00;
        endcase
      end
      default: begin
        case (ps_now)
          PS_S5S0: sq = SEQ_S5S0;
          PS_S3S0: sq = SEQ_S3S0;
          PS_S0S3: sq = SEQ_S0S3;
          default: sq = SEQ_S0S5;
        endcase
        if (ps_now == PS_S5S0) p[5] = (g != GOAL_OFF);
        r = step_row(sq, idx_now);
        if (r.pin != PIN_NONE && $urandom_range(0, 3) != 0) p[int'(r.pin) - 1] = r.lvl;
      end
    endcase
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // one tick transfer, then maybe a gap between bursts
  task automatic send_tick(input logic [5:0] p);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tick(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // writes all three limit registers back to back
  task automatic load_limits(input logic [7:0] deb, input logic [7:0] tmo,
                             input logic [7:0] wake);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_S0_EXIT_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= CFG_MAIN_POWER_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= CFG_S3_WAKE_DELAY;
    cfg_wdata <= wake;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_lim = deb;
    mp_timeout   = tmo;
    wake_dly     = wake;
  endtask

  task automatic steer(input pwr_state_t target, input int cap);
    int n;
    n = 0;
    while (ps_now != target && n < cap) begin
      send_tick(pick_pins(goal_toward(target)));
      n++;
    end
  endtask

  task automatic run_ticks(input goal_t g, input int n);
    repeat (n) send_tick(pick_pins(g));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // S5 holds until both sleep pins are high; main power gates the walk
  task automatic test_wake_from_off();
    send_tick(6'b000000);
    send_tick(6'b111100);
    send_tick(6'b000001);
    send_tick(6'b000010);
    send_tick(6'b011111);
    send_tick(6'b011111);
    send_tick(6'b111111);
    send_tick(6'b000000);
    send_tick(6'b000000);
    send_tick(6'b000000);
    send_tick(6'b100000);
    send_tick(6'b111111);
  endtask

  // whole power-up table with no main-power abort
  task automatic test_power_up();
    load_limits(8'd0, 8'd255, 8'd0);
    noise_pct = 0;
    steer(PS_S0, 400);
    noise_pct = 12;
    wait_idle();
  endtask

  // SLP_S3 high clears the debounce count; power down starts once the
  // count is above the limit, then the S0 -> S3 table begins
  task automatic test_s0_exit();
    load_limits(8'd2, 8'd50, 8'd20);
    send_tick(6'b000011);
    send_tick(6'b000010);
    send_tick(6'b000010);
    send_tick(6'b000011);
    send_tick(6'b000010);
    send_tick(6'b000010);
    send_tick(6'b000010);
    send_tick(6'b000010);
    run_ticks(GOAL_SLEEP, 6);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < 50)
      $display("%0t: report %0d %s mismatch: got %0h want %0h", $realtime, reports_seen,
               what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_reports
    step_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected transfer", out_tdata, 0);
      end else begin
        want = expected_reports.pop_front();
        if (out_tdata[0] !== want.done)    flag_mismatch("step_done", out_tdata[0], want.done);
        if (out_tdata[2:1] !== want.sq)    flag_mismatch("sequence", out_tdata[2:1], want.sq);
        if (out_tdata[6:3] !== want.step)  flag_mismatch("step", out_tdata[6:3], want.step);
        if (out_tdata[9:7] !== want.ps)    flag_mismatch("power_state", out_tdata[9:7], want.ps);
        if (out_tlast !== want.is_last)    flag_mismatch("tlast", out_tlast, want.is_last);
      end
      reports_seen++;
    end
  end

  // receiver: always ready, random, fixed mask and long stalls in turn
  always @(posedge clk) begin : rx_stalls
    rx_cyc++;
    case ((rx_cyc >> 8) % 4)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= RX_MASK[rx_cyc % 16];
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_tready <= 1'b0;
        end else begin
          if ($urandom_range(0, 9) == 0) rx_hold = $urandom_range(1, 24);
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) @(posedge clk) cycle_count++;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    ps_now       = PS_S5;
    idx_now      = '0;
    dly_now      = '0;
    deb_cnt      = '0;
    mpw_cnt      = '0;
    debounce_lim = S0_EXIT_DEBOUNCE_RST;
    mp_timeout   = MAIN_POWER_TIMEOUT_RST;
    wake_dly     = S3_WAKE_DELAY_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wake_from_off();
    wait_idle();
    test_power_up();
    test_s0_exit();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
